[rtl/core/ctq_pkg.sv]
package ctq_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int MAX_RESULTS = 32;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int BUF_DEPTH   = (QUEUE_DEPTH < MAX_RESULTS) ? QUEUE_DEPTH : MAX_RESULTS;
    localparam int BUF_AW      = $clog2(BUF_DEPTH);

    localparam int TIME_W = 32;
    localparam int CONN_W = 12;
    localparam int SEQ_W  = 32;
    localparam int WAIT_W = 16;
    localparam int COUNT_OUT_W = 6;

    // stream payload widths, rounded up to whole bytes
    localparam int S_DATA_W = 80;
    localparam int M_DATA_W = 88;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_DEL   = 2'd1,
        OP_POLL  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef enum logic {
        REG_WAIT = 1'b0,
        REG_KICK = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [TIME_W-1:0] expiry;
        logic [CONN_W-1:0] connection;
        logic [SEQ_W-1:0]  seq_tag;
    } entry_t;

    typedef struct packed {
        logic [CONN_W-1:0] connection;
        logic [SEQ_W-1:0]  seq_tag;
    } held_t;

    typedef struct packed {
        logic le;
        logic conn_eq;
    } cmp_t;

endpackage

[rtl/core/ctq_ram.sv]
module ctq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/ctq_cmp.sv]
module ctq_cmp (
    input  logic [ctq_pkg::TIME_W-1:0] expiry,
    input  logic [ctq_pkg::TIME_W-1:0] operand,
    input  logic [ctq_pkg::CONN_W-1:0] conn_a,
    input  logic [ctq_pkg::CONN_W-1:0] conn_b,
    output ctq_pkg::cmp_t              result
);
    import ctq_pkg::*;

    always_comb begin
        result.le      = (expiry <= operand);
        result.conn_eq = (conn_a == conn_b);
    end

endmodule

[rtl/core/connection_timeout_queue.sv]
// connection timeout queue: a table of pending timeouts kept in expiry order.
// input stream s_*: one command per transaction (add, delete, poll, clear).
// result stream m_*: each command gives one result, a poll gives one result
// per expired entry (at most 32); m_tlast marks the final result of a command.
// every result carries the entry count and head expiry after the command.
// apb port: register 0 wait_seconds (byte 0), register 1 kick_on_timeout (byte 4).
// the table sits in a single-port-read ram, so every sweep reads each entry in a
// _RD state and evaluates it in the matching _EV state; one comparator is reused
// by all sweeps under the sequencer. results leave one at a time, each read from
// the holding buffer before it is loaded into the output register; after the
// final result the sequencer returns to idle.
// s_tready is high only while the sequencer is idle; the final result may still
// wait in the output register while the next command is taken.
// a stalled receiver holds the sequencer in its emit step, nothing is lost.
// reset (aresetn low, synchronous) empties the table and sets wait_seconds to
// 20 and kick_on_timeout to 0; no clearing pass is needed.
module connection_timeout_queue (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // opcode[1:0], connection_id[13:2], sequence_tag[45:14], current_time[77:46]
    input  logic [ctq_pkg::S_DATA_W-1:0] s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // expired_connection[11:0], expired_sequence[43:12], entry_count[49:44],
    // earliest_expiry[81:50], full_error[82]
    output logic [ctq_pkg::M_DATA_W-1:0] m_tdata,
    // expired_valid[0]
    output logic                         m_tuser,
    output logic                         m_tlast,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ctq_pkg::APB_AW-1:0]   paddr,
    input  logic [ctq_pkg::APB_DW-1:0]   pwdata,
    output logic [ctq_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);
    import ctq_pkg::*;

    typedef enum logic [17:0] {
        ST_IDLE   = 18'h00001,
        ST_ADD_RD = 18'h00002,
        ST_ADD_EV = 18'h00004,
        ST_DEL_RD = 18'h00008,
        ST_DEL_EV = 18'h00010,
        ST_PSC_RD = 18'h00020,
        ST_PSC_EV = 18'h00040,
        ST_PCP_RD = 18'h00080,
        ST_PCP_EV = 18'h00100,
        ST_PSH_RD = 18'h00200,
        ST_PSH_EV = 18'h00400,
        ST_PFL_RD = 18'h00800,
        ST_PFL_EV = 18'h01000,
        ST_HD_RD  = 18'h02000,
        ST_HD_EV  = 18'h04000,
        ST_EM_RD  = 18'h08000,
        ST_EM_LD  = 18'h10000,
        ST_SPARE  = 18'h20000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CONN_W-1:0] conn_reg, conn_next;
    logic [SEQ_W-1:0]  seq_reg, seq_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic [TIME_W-1:0] key_reg, key_next;
    logic [CNT_W-1:0]  i_reg, i_next;
    logic [CNT_W-1:0]  j_reg, j_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic [CNT_W-1:0]  t_reg, t_next;
    logic              full_reg, full_next;
    logic [TIME_W-1:0] head_reg, head_next;
    logic [WAIT_W-1:0] wait_reg;
    logic              kick_reg;

    logic                m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;
    logic                m_user_reg;
    logic                m_last_reg;

    // input unpack
    op_t               in_op;
    logic [CONN_W-1:0] in_conn;
    logic [SEQ_W-1:0]  in_seq;
    logic [TIME_W-1:0] in_now;
    logic [TIME_W:0]   key_sum;
    logic [TIME_W-1:0] in_key;

    // table and holding buffer ports
    logic              tbl_we;
    logic [IDX_W-1:0]  tbl_waddr, tbl_raddr;
    entry_t            tbl_wdata, tbl_rdata;
    logic              buf_we;
    logic [BUF_AW-1:0] buf_waddr, buf_raddr;
    held_t             buf_wdata, buf_rdata;

    logic [TIME_W-1:0] cmp_operand;
    cmp_t              cmp;

    logic [CNT_W-1:0]  i_dec, i_inc, i_sub_k, i_dec_k, j_plus_t, t_inc, cnt_inc;
    entry_t            new_entry;
    logic              out_free, out_load, emit_entry, last_now;
    logic [M_DATA_W-1:0] out_data;

    assign in_op   = op_t'(s_tdata[1:0]);
    assign in_conn = s_tdata[13:2];
    assign in_seq  = s_tdata[45:14];
    assign in_now  = s_tdata[77:46];
    assign key_sum = {1'b0, in_now} + {{(TIME_W + 1 - WAIT_W){1'b0}}, wait_reg};
    // expiry saturates at all ones
    assign in_key  = key_sum[TIME_W] ? {TIME_W{1'b1}} : key_sum[TIME_W-1:0];

    assign i_dec    = i_reg - CNT_W'(1);
    assign i_inc    = i_reg + CNT_W'(1);
    assign i_sub_k  = i_reg - k_reg;
    assign i_dec_k  = i_dec + k_reg;
    assign j_plus_t = j_reg + t_reg;
    assign t_inc    = t_reg + CNT_W'(1);
    assign cnt_inc  = count_reg + CNT_W'(1);

    assign new_entry  = '{expiry: key_reg, connection: conn_reg, seq_tag: seq_reg};
    assign out_free   = !m_valid_reg || m_tready;
    assign emit_entry = (k_reg != '0);
    assign last_now   = !emit_entry || (t_inc == k_reg);

    ctq_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    ctq_ram #(
        .WIDTH ($bits(held_t)),
        .DEPTH (BUF_DEPTH)
    ) u_held (
        .aclk  (aclk),
        .we    (buf_we),
        .waddr (buf_waddr),
        .wdata (buf_wdata),
        .raddr (buf_raddr),
        .rdata (buf_rdata)
    );

    ctq_cmp u_cmp (
        .expiry  (tbl_rdata.expiry),
        .operand (cmp_operand),
        .conn_a  (tbl_rdata.connection),
        .conn_b  (conn_reg),
        .result  (cmp)
    );

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        conn_next   = conn_reg;
        seq_next    = seq_reg;
        now_next    = now_reg;
        key_next    = key_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        t_next      = t_reg;
        full_next   = full_reg;
        head_next   = head_reg;
        tbl_we      = 1'b0;
        tbl_waddr   = i_reg[IDX_W-1:0];
        tbl_wdata   = tbl_rdata;
        tbl_raddr   = i_reg[IDX_W-1:0];
        buf_we      = 1'b0;
        buf_waddr   = k_reg[BUF_AW-1:0];
        buf_wdata   = '{connection: tbl_rdata.connection, seq_tag: tbl_rdata.seq_tag};
        buf_raddr   = t_reg[BUF_AW-1:0];
        cmp_operand = key_reg;
        out_load    = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    conn_next = in_conn;
                    seq_next  = in_seq;
                    now_next  = in_now;
                    key_next  = in_key;
                    i_next    = '0;
                    j_next    = '0;
                    k_next    = '0;
                    full_next = 1'b0;
                    case (in_op)
                        OP_ADD: begin
                            if (count_reg == CNT_W'(QUEUE_DEPTH)) begin
                                full_next  = 1'b1;
                                state_next = ST_HD_RD;
                            end else begin
                                i_next     = count_reg;
                                state_next = ST_ADD_RD;
                            end
                        end
                        OP_DEL:  state_next = ST_DEL_RD;
                        OP_POLL: state_next = ST_PSC_RD;
                        OP_CLEAR: begin
                            count_next = '0;
                            state_next = ST_HD_RD;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end

            // add: walk down from the tail, moving later expiries up one slot
            ST_ADD_RD: begin
                if (i_reg == '0) begin
                    tbl_we     = 1'b1;
                    tbl_waddr  = '0;
                    tbl_wdata  = new_entry;
                    count_next = cnt_inc;
                    state_next = ST_HD_RD;
                end else begin
                    tbl_raddr  = i_dec[IDX_W-1:0];
                    state_next = ST_ADD_EV;
                end
            end
            ST_ADD_EV: begin
                tbl_we    = 1'b1;
                tbl_waddr = i_reg[IDX_W-1:0];
                if (!cmp.le) begin
                    tbl_wdata  = tbl_rdata;
                    i_next     = i_dec;
                    state_next = ST_ADD_RD;
                end else begin
                    tbl_wdata  = new_entry;
                    count_next = cnt_inc;
                    state_next = ST_HD_RD;
                end
            end

            // delete: compact the survivors toward the head
            ST_DEL_RD: begin
                if (i_reg == count_reg) begin
                    count_next = j_reg;
                    state_next = ST_HD_RD;
                end else begin
                    state_next = ST_DEL_EV;
                end
            end
            ST_DEL_EV: begin
                if (!cmp.conn_eq) begin
                    tbl_we    = 1'b1;
                    tbl_waddr = j_reg[IDX_W-1:0];
                    j_next    = j_reg + CNT_W'(1);
                end
                i_next     = i_inc;
                state_next = ST_DEL_RD;
            end

            // poll scan: expired head entries go to the holding buffer
            ST_PSC_RD: begin
                if (i_reg < count_reg && k_reg < CNT_W'(BUF_DEPTH)) begin
                    state_next = ST_PSC_EV;
                end else if (k_reg == '0) begin
                    state_next = ST_HD_RD;
                end else begin
                    state_next = ST_PCP_RD;
                end
            end
            ST_PSC_EV: begin
                cmp_operand = now_reg;
                if (cmp.le) begin
                    buf_we     = 1'b1;
                    k_next     = k_reg + CNT_W'(1);
                    i_next     = i_inc;
                    state_next = ST_PSC_RD;
                end else if (k_reg == '0) begin
                    state_next = ST_HD_RD;
                end else begin
                    state_next = ST_PCP_RD;
                end
            end

            // drop the emitted head by moving the rest down k slots
            ST_PCP_RD: begin
                if (i_reg == count_reg) begin
                    count_next = i_sub_k;
                    i_next     = i_sub_k;
                    state_next = kick_reg ? ST_HD_RD : ST_PSH_RD;
                end else begin
                    state_next = ST_PCP_EV;
                end
            end
            ST_PCP_EV: begin
                tbl_we     = 1'b1;
                tbl_waddr  = i_sub_k[IDX_W-1:0];
                i_next     = i_inc;
                state_next = ST_PCP_RD;
            end

            // re-arm: open a gap of k slots after the last expiry at or below the key
            ST_PSH_RD: begin
                if (i_reg == '0) begin
                    j_next     = '0;
                    t_next     = '0;
                    state_next = ST_PFL_RD;
                end else begin
                    tbl_raddr  = i_dec[IDX_W-1:0];
                    state_next = ST_PSH_EV;
                end
            end
            ST_PSH_EV: begin
                if (!cmp.le) begin
                    tbl_we     = 1'b1;
                    tbl_waddr  = i_dec_k[IDX_W-1:0];
                    i_next     = i_dec;
                    state_next = ST_PSH_RD;
                end else begin
                    j_next     = i_reg;
                    t_next     = '0;
                    state_next = ST_PFL_RD;
                end
            end
            ST_PFL_RD: begin
                if (t_reg == k_reg) begin
                    count_next = count_reg + k_reg;
                    state_next = ST_HD_RD;
                end else begin
                    state_next = ST_PFL_EV;
                end
            end
            ST_PFL_EV: begin
                tbl_we     = 1'b1;
                tbl_waddr  = j_plus_t[IDX_W-1:0];
                tbl_wdata  = '{expiry: key_reg, connection: buf_rdata.connection,
                               seq_tag: buf_rdata.seq_tag};
                t_next     = t_inc;
                state_next = ST_PFL_RD;
            end

            ST_HD_RD: begin
                tbl_raddr  = '0;
                t_next     = '0;
                state_next = ST_HD_EV;
            end
            ST_HD_EV: begin
                head_next  = (count_reg != '0) ? tbl_rdata.expiry : '0;
                state_next = ST_EM_RD;
            end

            ST_EM_RD: begin
                state_next = ST_EM_LD;
            end
            ST_EM_LD: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (last_now) begin
                        state_next = ST_IDLE;
                    end else begin
                        t_next     = t_inc;
                        state_next = ST_EM_RD;
                    end
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        out_data = '0;
        if (emit_entry) begin
            out_data[11:0]  = buf_rdata.connection;
            out_data[43:12] = buf_rdata.seq_tag;
        end
        out_data[49:44] = COUNT_OUT_W'(count_reg);
        out_data[81:50] = head_reg;
        out_data[82]    = full_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            k_reg     <= '0;
            t_reg     <= '0;
            full_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            k_reg     <= k_next;
            t_reg     <= t_next;
            full_reg  <= full_next;
        end
    end

    always_ff @(posedge aclk) begin
        conn_reg <= conn_next;
        seq_reg  <= seq_next;
        now_reg  <= now_next;
        key_reg  <= key_next;
        i_reg    <= i_next;
        j_reg    <= j_next;
        head_reg <= head_next;
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= out_data;
            m_user_reg <= emit_entry;
            m_last_reg <= last_now;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wait_reg <= WAIT_W'(20);
            kick_reg <= 1'b0;
        end else if (psel && penable && pwrite) begin
            case (reg_idx_t'(paddr[2]))
                REG_WAIT: wait_reg <= pwdata[WAIT_W-1:0];
                REG_KICK: kick_reg <= pwdata[0];
                default:  wait_reg <= wait_reg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx_t'(paddr[2]))
            REG_WAIT: prdata = {{(APB_DW - WAIT_W){1'b0}}, wait_reg};
            REG_KICK: prdata = {{(APB_DW - 1){1'b0}}, kick_reg};
            default:  prdata = '0;
        endcase
    end

    assign pready   = 1'b1;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule
